// ----- hdl/sfrc_pkg.sv -----
// Shared types, constants and status codes for the serial frame receiver.
package sfrc_pkg;

  localparam int unsigned MAX_FRAME = 1024;

  localparam logic [7:0]  GAP_TICKS_RESET = 8'd10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  HDR_SYNC0       = 8'h55;
  localparam logic [7:0]  HDR_SYNC1       = 8'h7A;
  localparam int unsigned FRAME_OVERHEAD  = 9;
  localparam int unsigned HDR_BYTES       = 7;
  localparam int unsigned IDLE_W          = 9;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_LEN_MISM   = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_BAD_CRC    = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_e;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version_byte;
    logic [7:0]  comm_number;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic [10:0] frame_length;
  } out_word_t;

endpackage

// ----- hdl/sfrc_crc_byte.sv -----
// Byte-wide CRC-16/MODBUS update (reflected polynomial).
module sfrc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ sfrc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ----- hdl/sfrc_frame_track.sv -----
// Frame state, gap detection and end-of-frame checks.
module sfrc_frame_track #(
  parameter int unsigned MaxFrame = sfrc_pkg::MAX_FRAME
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sfrc_pkg::in_word_t  word_i,
  input  logic [7:0]          gap_ticks_i,
  output logic                emit_o,
  output sfrc_pkg::out_word_t result_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned CmpW = (CntW > 17) ? CntW : 17;
  localparam int unsigned IdleW = sfrc_pkg::IDLE_W;

  logic [CntW-1:0]  byte_count_q, byte_count_d;
  logic [IdleW-1:0] idle_count_q, idle_count_d, idle_inc;
  logic [15:0]      crc_q, crc_d, crc_next;
  logic [7:0]       tail_q [2];
  logic [7:0]       tail_d [2];
  logic [7:0]       hdr_q [sfrc_pkg::HDR_BYTES];
  logic [7:0]       hdr_d [sfrc_pkg::HDR_BYTES];
  logic             ovf_q, ovf_d;

  logic             is_tick;
  logic             full;
  logic [15:0]      plen;
  logic [15:0]      rx_crc;
  logic [CmpW-1:0]  want_len;
  sfrc_pkg::status_e status;

  sfrc_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (tail_q[0]),
    .crc_o  (crc_next)
  );

  assign is_tick  = (word_i.func == sfrc_pkg::FUNC_TICK);
  assign full     = (byte_count_q >= CntW'(MaxFrame));
  assign idle_inc = (idle_count_q == {IdleW{1'b1}}) ? idle_count_q : idle_count_q + 1'b1;
  assign emit_o   = is_tick && (byte_count_q != '0) && (idle_inc > {1'b0, gap_ticks_i});

  assign plen     = {hdr_q[5], hdr_q[6]};
  assign rx_crc   = {tail_q[0], tail_q[1]};
  assign want_len = CmpW'(plen) + CmpW'(sfrc_pkg::FRAME_OVERHEAD);

  always_comb begin
    if (ovf_q) begin
      status = sfrc_pkg::ST_OVERFLOW;
    end else if (byte_count_q < CntW'(sfrc_pkg::FRAME_OVERHEAD)) begin
      status = sfrc_pkg::ST_TOO_SHORT;
    end else if (CmpW'(byte_count_q) != want_len) begin
      status = sfrc_pkg::ST_LEN_MISM;
    end else if (hdr_q[0] != sfrc_pkg::HDR_SYNC0 || hdr_q[1] != sfrc_pkg::HDR_SYNC1) begin
      status = sfrc_pkg::ST_BAD_HEADER;
    end else if (rx_crc != crc_q) begin
      status = sfrc_pkg::ST_BAD_CRC;
    end else begin
      status = sfrc_pkg::ST_OK;
    end
  end

  always_comb begin
    result_o.status         = status;
    result_o.version_byte   = hdr_q[2];
    result_o.comm_number    = hdr_q[3];
    result_o.command_code   = hdr_q[4];
    result_o.payload_length = plen;
    result_o.frame_length   = 11'(byte_count_q);
  end

  always_comb begin
    byte_count_d = byte_count_q;
    idle_count_d = idle_count_q;
    crc_d        = crc_q;
    tail_d       = tail_q;
    hdr_d        = hdr_q;
    ovf_d        = ovf_q;
    if (step_i) begin
      if (!is_tick) begin
        idle_count_d = '0;
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          if (byte_count_q >= CntW'(2)) begin
            crc_d = crc_next;
          end
          tail_d[0] = tail_q[1];
          tail_d[1] = word_i.rx_byte;
          for (int i = 0; i < sfrc_pkg::HDR_BYTES; i++) begin
            if (byte_count_q == CntW'(i)) begin
              hdr_d[i] = word_i.rx_byte;
            end
          end
          byte_count_d = byte_count_q + 1'b1;
        end
      end else if (byte_count_q != '0) begin
        if (emit_o) begin
          byte_count_d = '0;
          idle_count_d = '0;
          crc_d        = sfrc_pkg::CRC_INIT;
          tail_d[0]    = '0;
          tail_d[1]    = '0;
          for (int i = 0; i < sfrc_pkg::HDR_BYTES; i++) begin
            hdr_d[i] = '0;
          end
          ovf_d        = 1'b0;
        end else begin
          idle_count_d = idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      idle_count_q <= '0;
      crc_q        <= sfrc_pkg::CRC_INIT;
      tail_q[0]    <= '0;
      tail_q[1]    <= '0;
      for (int i = 0; i < sfrc_pkg::HDR_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
      ovf_q        <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      idle_count_q <= idle_count_d;
      crc_q        <= crc_d;
      tail_q       <= tail_d;
      hdr_q        <= hdr_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

// ----- hdl/serial_frame_receiver_crc16.sv -----
// Top level of the gap-delimited serial frame receiver with CRC-16 check.
//
// The input channel (in_valid_i / in_ready_o / in_data_i) carries one word per
// handshake: either a received serial byte or a one-millisecond tick. A frame
// is closed by the tick that takes the idle count past gap_ticks; that word
// produces one result word on the output channel (out_valid_o / out_ready_i /
// out_data_o) holding the status and the header fields. Every other word
// produces no result.
// An accepted word is held in the input register, where it is folded into the
// frame state; a closing tick's result is then registered in the result register.
// Unless a closing tick waits on a full result register, the block takes one word
// per cycle, as the byte-wide CRC update on the frame state is combinational.
// If the receiver stalls, a pending result waits in the output register while
// bytes and non-closing ticks keep flowing; only a second closing tick waits,
// which in turn holds in_ready_o low until the result is taken.
// gap_ticks is written through cfg_we_i / cfg_wdata_i at any idle moment.
// Reset clears all frame state, empties both registers and sets gap_ticks to
// ten; there is no clearing pass, so the block is ready straight after reset.
module serial_frame_receiver_crc16 #(
  parameter int unsigned MaxFrame = sfrc_pkg::MAX_FRAME
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfrc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfrc_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  // Gap threshold register.
  logic [7:0] gap_q;

  // Input register: holds one word awaiting processing.
  logic               in_vld_q;
  sfrc_pkg::in_word_t in_word_q;

  // Result register.
  logic                out_vld_q;
  sfrc_pkg::out_word_t out_word_q;

  logic                emit;
  logic                step;
  sfrc_pkg::out_word_t result;

  // The held word may be processed unless it would produce a result while the
  // result register is still full and not being emptied this cycle.
  assign step       = in_vld_q && (!emit || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  sfrc_frame_track #(
    .MaxFrame (MaxFrame)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (in_word_q),
    .gap_ticks_i (gap_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= sfrc_pkg::GAP_TICKS_RESET;
    end else if (cfg_we_i) begin
      gap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_word_q;

endmodule

// ----- hdl/sfrc_checker.sv -----
// Port-level assertions for the frame receiver, bound to the top level.
module sfrc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sfrc_pkg::out_word_t out_data_o
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= sfrc_pkg::ST_OVERFLOW)
    else $error("status code out of range");

  // A good frame must agree with its own length field.
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sfrc_pkg::ST_OK |->
      out_data_o.frame_length == 11'(out_data_o.payload_length + 16'd9))
    else $error("good frame with inconsistent length");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sfrc_pkg::ST_TOO_SHORT |->
      out_data_o.frame_length < 11'd9 && out_data_o.frame_length != 11'd0)
    else $error("short frame with wrong length");

endmodule

bind serial_frame_receiver_crc16 sfrc_checker u_sfrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- bench/serial_frame_receiver_crc16_tb.sv -----
// Self-checking testbench for the gap-delimited serial frame receiver with CRC-16 check.
module serial_frame_receiver_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // No word crosses either channel for this many cycles only if the block has hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off plus one
  // idle burst on each side, so this leaves ample margin.
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned NUM_PHASES    = 4;
  localparam int unsigned PHASE_WORDS   = 80;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready_o;
  sfrc_pkg::in_word_t  in_data   = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  sfrc_pkg::out_word_t out_data_o;
  logic                cfg_we    = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  serial_frame_receiver_crc16 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 20 ns period: ten high, ten low.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Words waiting to be offered, filled by the stimulus process and drained
  // by the driver. The two counters let the stimulus process tell when every
  // word it queued has actually crossed the input handshake.
  sfrc_pkg::in_word_t pending_words[$];
  int unsigned        words_queued = 0;
  int unsigned        words_taken  = 0;
  int unsigned        stim_count   = 0;

  // Result words predicted at frame end, oldest first.
  sfrc_pkg::out_word_t expected_reports[$];
  int unsigned         error_count = 0;

  // Shared control flags, each written by the stimulus process only.
  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;

  // Predictor copy of the block's frame state and its one setting.
  logic [7:0]  gap_setting;
  logic [10:0] fr_count;
  logic [8:0]  fr_idle;
  logic [15:0] fr_crc;
  logic [7:0]  fr_tail[2];
  logic [7:0]  fr_hdr[sfrc_pkg::HDR_BYTES];
  logic        fr_overflow;

  // Every mismatch goes through here so that the count and the printed lines
  // stay in step.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // One byte through the reflected CRC-16 with polynomial 0xA001, LSB first.
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ sfrc_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic clear_frame_state();
    fr_count    = '0;
    fr_idle     = '0;
    fr_crc      = sfrc_pkg::CRC_INIT;
    fr_tail[0]  = '0;
    fr_tail[1]  = '0;
    foreach (fr_hdr[i]) fr_hdr[i] = '0;
    fr_overflow = 1'b0;
  endtask

  // Fold one accepted word into the predicted frame state. A byte feeds the
  // CRC through the two-byte delay, so the last two bytes of a frame never
  // reach it and are left to be compared as the received CRC. A tick that
  // takes the idle count past the gap setting closes the frame and yields
  // the one result word, checked in priority order.
  task automatic track_frame(input sfrc_pkg::in_word_t w);
    sfrc_pkg::out_word_t res;
    int unsigned         plen_v;
    logic [15:0]         crc_rx;
    if (w.func == sfrc_pkg::FUNC_BYTE) begin
      fr_idle = '0;
      if (fr_count >= sfrc_pkg::MAX_FRAME) begin
        // A full frame drops the byte but remembers the overflow.
        fr_overflow = 1'b1;
      end else begin
        if (fr_count >= 2) fr_crc = crc16_modbus_byte(fr_crc, fr_tail[0]);
        fr_tail[0] = fr_tail[1];
        fr_tail[1] = w.rx_byte;
        if (fr_count < sfrc_pkg::HDR_BYTES) fr_hdr[fr_count] = w.rx_byte;
        fr_count++;
      end
    end else if (fr_count != 0) begin
      // Ticks outside a frame do nothing at all.
      if (fr_idle < 9'd511) fr_idle++;
      if (fr_idle > {1'b0, gap_setting}) begin
        plen_v = 32'({fr_hdr[5], fr_hdr[6]});
        crc_rx = {fr_tail[0], fr_tail[1]};
        if (fr_overflow) res.status = sfrc_pkg::ST_OVERFLOW;
        else if (fr_count < sfrc_pkg::FRAME_OVERHEAD) res.status = sfrc_pkg::ST_TOO_SHORT;
        else if (int'(fr_count) != plen_v + sfrc_pkg::FRAME_OVERHEAD)
          res.status = sfrc_pkg::ST_LEN_MISM;
        else if (fr_hdr[0] != sfrc_pkg::HDR_SYNC0 || fr_hdr[1] != sfrc_pkg::HDR_SYNC1)
          res.status = sfrc_pkg::ST_BAD_HEADER;
        else if (crc_rx != fr_crc) res.status = sfrc_pkg::ST_BAD_CRC;
        else res.status = sfrc_pkg::ST_OK;
        res.version_byte   = fr_hdr[2];
        res.comm_number    = fr_hdr[3];
        res.command_code   = fr_hdr[4];
        res.payload_length = plen_v[15:0];
        res.frame_length   = fr_count;
        expected_reports.push_back(res);
        clear_frame_state();
      end
    end
  endtask

  task automatic check_report(input sfrc_pkg::out_word_t got);
    sfrc_pkg::out_word_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result word %h arrived with no frame end pending", got));
      return;
    end
    want = expected_reports.pop_front();
    if (got.status != want.status)
      report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
    if (got.version_byte != want.version_byte)
      report_mismatch($sformatf("version_byte %h, predicted %h", got.version_byte,
                                want.version_byte));
    if (got.comm_number != want.comm_number)
      report_mismatch($sformatf("comm_number %h, predicted %h", got.comm_number,
                                want.comm_number));
    if (got.command_code != want.command_code)
      report_mismatch($sformatf("command_code %h, predicted %h", got.command_code,
                                want.command_code));
    if (got.payload_length != want.payload_length)
      report_mismatch($sformatf("payload_length %h, predicted %h", got.payload_length,
                                want.payload_length));
    if (got.frame_length != want.frame_length)
      report_mismatch($sformatf("frame_length %0d, predicted %0d", got.frame_length,
                                want.frame_length));
  endtask

  // Input driver. A new word is only put up once the previous one has been
  // taken, and valid holds with the payload steady while the block stalls.
  // After a word is put up, the next may be held back by a short idle burst.
  int unsigned send_pause = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      send_pause <= 0;
    end else if (!in_valid || in_ready_o) begin
      if (send_pause != 0) begin
        send_pause <= send_pause - 1;
        in_valid   <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) send_pause <= $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. Ready drops in short random bursts, and once, on request,
  // for a long hold-off counted here, during which the sender keeps offering
  // closing ticks so that the pending result backs the block up to its input.
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: both handshakes are sampled at the clock edge, before any of this
  // edge's updates take effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        track_frame(in_data);
        words_taken++;
      end
      if (out_valid_o && out_ready) check_report(out_data_o);
    end
  end

  // Watchdog on cycles in which no word crosses either channel.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic f, input logic [7:0] b);
    sfrc_pkg::in_word_t w;
    w.func    = f;
    w.rx_byte = b;
    pending_words.push_back(w);
    words_queued++;
    stim_count++;
  endtask

  // Enough ticks to end the frame under the current setting, sometimes with a
  // few more that land on an empty receiver.
  task automatic close_frame();
    repeat (int'(gap_setting) + 1 + $urandom_range(0, 2))
      push_word(sfrc_pkg::FUNC_TICK, 8'h00);
  endtask

  // Queue a frame with the sync header, three random header bytes, the length
  // field, a body and the CRC, high byte first. A bad header or CRC is made by
  // flipping one bit, so it is certain to differ. With split set, runs of
  // ticks no longer than the gap setting are slipped in between bytes; a run
  // of exactly the gap setting must not end the frame.
  task automatic queue_frame(input int unsigned plen, input int unsigned body,
                             input bit hdr_ok, input bit crc_ok, input bit split);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int unsigned n;
    int unsigned idx;
    fb.push_back(sfrc_pkg::HDR_SYNC0);
    fb.push_back(sfrc_pkg::HDR_SYNC1);
    repeat (3) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(plen[15:8]);
    fb.push_back(plen[7:0]);
    repeat (body) fb.push_back(8'($urandom_range(0, 255)));
    if (!hdr_ok) begin
      idx = $urandom_range(0, 1);
      fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    crc = sfrc_pkg::CRC_INIT;
    foreach (fb[i]) crc = crc16_modbus_byte(crc, fb[i]);
    if (!crc_ok) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    foreach (fb[i]) begin
      push_word(sfrc_pkg::FUNC_BYTE, fb[i]);
      if (split && gap_setting != 0 && $urandom_range(0, 7) == 0) begin
        n = ($urandom_range(0, 3) == 0) ? int'(gap_setting)
            : $urandom_range(1, (gap_setting < 4) ? int'(gap_setting) : 4);
        repeat (n) push_word(sfrc_pkg::FUNC_TICK, 8'h00);
      end
    end
    close_frame();
  endtask

  // One random frame: mostly well formed, the rest with flaws or pure noise.
  task automatic queue_random_frame();
    int unsigned body;
    int unsigned kind;
    int unsigned n;
    body = $urandom_range(0, 6);
    kind = $urandom_range(0, 9);
    case (kind)
      6: queue_frame(body, body, 1'b1, 1'b0, 1'b1);
      7: queue_frame(body, body, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
      8: begin
        if ($urandom_range(0, 1) == 0)
          queue_frame(body + $urandom_range(1, 3), body, 1'b1, 1'b1, 1'b1);
        else
          queue_frame($urandom_range(0, 65535), body, 1'b1, 1'b1, 1'b1);
      end
      9: begin
        // Noise: random bytes, often fewer than a minimum frame.
        n = $urandom_range(1, 12);
        repeat (n) push_word(sfrc_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
        close_frame();
      end
      default: queue_frame(body, body, 1'b1, 1'b1, 1'b1);
    endcase
  endtask

  // Wait until every queued word has been taken and every predicted result has
  // arrived, then a few cycles more, since a word with no result may still be
  // inside the block.
  task automatic settle_block();
    while (words_taken != words_queued || expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gap(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    gap_setting = value;
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    logic [7:0]  g;

    gap_setting = sfrc_pkg::GAP_TICKS_RESET;
    clear_frame_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A tick on an empty receiver, under the reset setting.
    push_word(sfrc_pkg::FUNC_TICK, 8'h00);
    settle_block();
    write_gap(8'd0);
    // A one-byte frame: header fields that were never received read zero.
    push_word(sfrc_pkg::FUNC_BYTE, 8'hFF);
    close_frame();
    // Eight bytes, one short of a minimum frame, with a correct sync header.
    push_word(sfrc_pkg::FUNC_BYTE, sfrc_pkg::HDR_SYNC0);
    push_word(sfrc_pkg::FUNC_BYTE, sfrc_pkg::HDR_SYNC1);
    push_word(sfrc_pkg::FUNC_BYTE, 8'h00);
    push_word(sfrc_pkg::FUNC_BYTE, 8'hFF);
    push_word(sfrc_pkg::FUNC_BYTE, 8'h01);
    push_word(sfrc_pkg::FUNC_BYTE, 8'h80);
    push_word(sfrc_pkg::FUNC_BYTE, 8'h00);
    push_word(sfrc_pkg::FUNC_BYTE, 8'hFE);
    close_frame();
    // The smallest good frame: empty payload.
    queue_frame(0, 0, 1'b1, 1'b1, 1'b0);

    // Random part, in phases that each run under one gap setting. The first
    // restores the reset value, the second uses the largest gap with a single
    // frame since it needs 256 closing ticks, the third uses no gap at all and
    // carries the receiver hold-off. The last carries the overflow frame and
    // runs without idling.
    stim_count = 0;
    phase = 0;
    while (phase < NUM_PHASES) begin
      case (phase)
        0: g = sfrc_pkg::GAP_TICKS_RESET;
        1: g = 8'd255;
        2: g = 8'd0;
        default: g = 8'($urandom_range(1, 12));
      endcase
      settle_block();
      if (phase == NUM_PHASES - 1) idling_on = 1'b0;
      write_gap(g);
      phase_start = stim_count;
      if (phase == 1) begin
        queue_random_frame();
      end else begin
        if (phase == 2) begin
          // Back-to-back one-byte frames, each closed by a single tick, while
          // the receiver holds off: the block has to stall its input.
          hold_request = 1'b1;
          repeat (20) begin
            push_word(sfrc_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
            close_frame();
          end
        end
        if (phase == 3) begin
          // One frame of a byte more than the receiver holds: overflow, with
          // the frame length saturated.
          queue_frame(sfrc_pkg::MAX_FRAME - sfrc_pkg::FRAME_OVERHEAD + 1,
                      sfrc_pkg::MAX_FRAME - sfrc_pkg::FRAME_OVERHEAD + 1,
                      1'b1, 1'b1, 1'b0);
          phase_start = stim_count;
        end
        while (stim_count - phase_start < PHASE_WORDS) queue_random_frame();
      end
      phase++;
    end

    settle_block();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- serial_frame_receiver_crc16.f -----
hdl/sfrc_pkg.sv
hdl/sfrc_crc_byte.sv
hdl/sfrc_frame_track.sv
hdl/serial_frame_receiver_crc16.sv
hdl/sfrc_checker.sv
bench/serial_frame_receiver_crc16_tb.sv
